>>> hw/rtl/hbp_pkg.sv
// Shared types, constants and control structs of the Huffman bit packer.
package hbp_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned LEN_BITS   = 6;
  localparam int unsigned SYM_BITS   = 8;
  localparam int unsigned CMD_BITS   = 2;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned PEND_BITS  = 7;
  localparam int unsigned PCNT_BITS  = 3;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_CODE_LEN = 32;
  localparam int unsigned DEF_SYMBOL_COUNT = 256;

  // Command codes on in_cmd
  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } hbp_cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } hbp_state_t;

  // Sequencer to packer
  typedef struct packed {
    logic start_enc;    // build accumulator from table entry
    logic start_flush;  // build accumulator from pending bits
    logic emit;         // shift out one byte into the output register
    logic finish;       // store leftover bits, end of run
  } hbp_ctrl_t;

  // Packer to sequencer
  typedef struct packed {
    logic has_byte;     // at least one whole byte left in the accumulator
    logic out_free;     // output register can take a byte this cycle
    logic pend_empty;   // no pending bits
  } hbp_stat_t;

endpackage

>>> hw/rtl/huffman_bit_packer_top.sv
// Huffman bit packer top level: command decode, sequencer, table and packer.
//
// Usage: one input channel (in_valid/in_ready) carries commands. A load
// command writes a code word and length into the code table, an encode
// command looks up its symbol and packs the code bits MSB first into bytes,
// a flush command pads the partial byte with zeros and sends it out. Each
// finished byte is one transfer on the output channel (out_valid/out_ready)
// with its last_of_run flag and the saturating running byte count.
// Steps: a load, an ignored command, an encode of a symbol outside the table
// and a flush with nothing pending end in the idle state. An encode of n
// output bytes (0..4) does the registered table read, builds the accumulator,
// sends one byte per cycle through the single extract shifter while the
// output register is free, and stores the leftover bits. An encode of a
// zero-length entry ends after the table read. A flush with pending bits sends
// one byte and clears them. in_ready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) clears pending bits, byte count and the
// output valid flag; the code table holds no reset value and each entry must
// be loaded before it is encoded.
// When the receiver stalls, the current byte waits in the output register
// and the sequencer holds until that register is free; the next item is
// taken while the last byte of a run still waits.
module huffman_bit_packer_top #(
  parameter int unsigned MAX_CODE_LEN = hbp_pkg::DEF_MAX_CODE_LEN,
  parameter int unsigned SYMBOL_COUNT = hbp_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hbp_pkg::CMD_BITS-1:0]   in_cmd,
  input  logic [hbp_pkg::SYM_BITS-1:0]   in_symbol,
  input  logic [hbp_pkg::WORD_BITS-1:0]  in_code_word,
  input  logic [hbp_pkg::LEN_BITS-1:0]   in_code_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hbp_pkg::BYTE_BITS-1:0]  out_byte,
  output logic                           out_last_of_run,
  output logic [hbp_pkg::COUNT_BITS-1:0] out_bytes_emitted
);
  import hbp_pkg::*;

  localparam int unsigned CodeLimit = (MAX_CODE_LEN > WORD_BITS) ? WORD_BITS : MAX_CODE_LEN;
  localparam int unsigned LenW      = $clog2(CodeLimit + 1);
  localparam int unsigned AddrW     = $clog2(SYMBOL_COUNT);

  hbp_state_t          state_r, state_nxt;
  hbp_ctrl_t           ctrl;
  hbp_stat_t           stat;
  hbp_cmd_t            cmd;
  logic                accept;
  logic                sym_ok;
  logic                tbl_we, tbl_re;
  logic                flush_go;
  logic [LenW-1:0]     wr_len;
  logic [CodeLimit-1:0] rd_word;
  logic [LenW-1:0]     rd_len;

  assign cmd    = hbp_cmd_t'(in_cmd);
  assign accept = in_valid && in_ready;
  assign sym_ok = ({1'b0, in_symbol} < (SYM_BITS+1)'(SYMBOL_COUNT));

  // Clamp the code length on load
  assign wr_len = (in_code_length > LEN_BITS'(CodeLimit)) ? LenW'(CodeLimit)
                                                          : LenW'(in_code_length);

  // Command decode
  always_comb begin
    tbl_we   = 1'b0;
    tbl_re   = 1'b0;
    flush_go = 1'b0;
    unique case (cmd)
      CMD_LOAD:   tbl_we = accept && sym_ok;
      CMD_ENCODE: tbl_re = accept && sym_ok;
      CMD_FLUSH:  flush_go = accept && !stat.pend_empty;
      CMD_NONE:   ;
      default:    ;
    endcase
  end

  // Sequencer: next state and controls
  always_comb begin
    state_nxt        = state_r;
    in_ready         = 1'b0;
    ctrl.start_enc   = 1'b0;
    ctrl.start_flush = flush_go;
    ctrl.emit        = 1'b0;
    ctrl.finish      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (tbl_re) begin
          state_nxt = ST_LOOKUP;
        end else if (flush_go) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_LOOKUP: begin
        // zero length emits nothing, leaves the pending bits alone and returns to idle
        ctrl.start_enc = (rd_len != '0);
        state_nxt      = (rd_len != '0) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        ctrl.emit   = stat.has_byte && stat.out_free;
        ctrl.finish = !stat.has_byte;
        if (!stat.has_byte) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  hbp_table #(
    .DEPTH  (SYMBOL_COUNT),
    .ADDR_W (AddrW),
    .WORD_W (CodeLimit),
    .LEN_W  (LenW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (in_symbol[AddrW-1:0]),
    .wr_word (in_code_word[CodeLimit-1:0]),
    .wr_len  (wr_len),
    .rd_en   (tbl_re),
    .rd_addr (in_symbol[AddrW-1:0]),
    .rd_word (rd_word),
    .rd_len  (rd_len)
  );

  hbp_packer #(
    .CODE_W (CodeLimit),
    .LEN_W  (LenW)
  ) u_packer (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .stat              (stat),
    .tbl_word          (rd_word),
    .tbl_len           (rd_len),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_bytes_emitted (out_bytes_emitted)
  );

  // A new byte appears only from the emit state
  a_emit_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_EMIT))
    else $error("output byte not produced by the emit step");

  // Consecutive bytes carry consecutive counts until saturation
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && (out_bytes_emitted != '1)) |=>
      (!out_valid || (out_bytes_emitted == $past(out_bytes_emitted) + 32'd1)))
    else $error("byte count did not advance by one");

  // A flush with pending bits goes straight to byte emission
  a_flush_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start_flush |=> (state_r == ST_EMIT) && stat.has_byte)
    else $error("flush did not start a byte");

endmodule

>>> hw/rtl/hbp_table.sv
// Code table memory: one write port, one registered read port.
module hbp_table #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned WORD_W = 32,
  parameter int unsigned LEN_W  = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_word,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_word,
  output logic [LEN_W-1:0]  rd_len
);

  logic [LEN_W+WORD_W-1:0] mem [DEPTH];
  logic [LEN_W+WORD_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_len, wr_word};
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_word = rd_data_r[WORD_W-1:0];
  assign rd_len  = rd_data_r[LEN_W+WORD_W-1:WORD_W];

endmodule

>>> hw/rtl/hbp_packer.sv
// Bit accumulator with a shared byte extract shifter, pending bits,
// saturating byte counter and output register.
module hbp_packer #(
  parameter int unsigned CODE_W = 32,
  parameter int unsigned LEN_W  = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hbp_pkg::hbp_ctrl_t             ctrl,
  output hbp_pkg::hbp_stat_t             stat,
  input  logic [CODE_W-1:0]              tbl_word,
  input  logic [LEN_W-1:0]               tbl_len,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hbp_pkg::BYTE_BITS-1:0]  out_byte,
  output logic                           out_last_of_run,
  output logic [hbp_pkg::COUNT_BITS-1:0] out_bytes_emitted
);
  import hbp_pkg::*;

  localparam int unsigned AccW = ((CODE_W > BYTE_BITS) ? CODE_W : BYTE_BITS) + PEND_BITS;
  localparam int unsigned CntW = $clog2(AccW + 1);

  logic [AccW-1:0]       acc_r, acc_nxt;
  logic [CntW-1:0]       count_r, count_nxt;
  logic                  flush_r, flush_nxt;
  logic [PEND_BITS-1:0]  pend_r, pend_nxt;
  logic [PCNT_BITS-1:0]  pcnt_r, pcnt_nxt;
  logic [COUNT_BITS-1:0] bcount_r, bcount_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [BYTE_BITS-1:0]  obyte_r, obyte_nxt;
  logic                  olast_r, olast_nxt;

  logic [CODE_W:0]       code_mask;
  logic [CODE_W-1:0]     code_bits;
  logic [AccW-1:0]       shifted;
  logic [CntW-1:0]       count_less;

  // Shared extract shifter: byte that starts count-8 bits above the LSB
  assign count_less = count_r - CntW'(BYTE_BITS);
  assign shifted    = acc_r >> count_less;

  // Keep only the low tbl_len bits of the code word
  assign code_mask = ~({(CODE_W+1){1'b1}} << tbl_len);
  assign code_bits = tbl_word & code_mask[CODE_W-1:0];

  assign stat.has_byte   = (count_r >= CntW'(BYTE_BITS));
  assign stat.out_free   = !ovalid_r || out_ready;
  assign stat.pend_empty = (pcnt_r == '0);

  // Next-state logic of the datapath
  always_comb begin
    acc_nxt    = acc_r;
    count_nxt  = count_r;
    flush_nxt  = flush_r;
    pend_nxt   = pend_r;
    pcnt_nxt   = pcnt_r;
    bcount_nxt = bcount_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r && !out_ready;

    if (ctrl.start_enc) begin
      acc_nxt   = (AccW'(pend_r) << tbl_len) | AccW'(code_bits);
      count_nxt = CntW'(pcnt_r) + CntW'(tbl_len);
      flush_nxt = 1'b0;
    end else if (ctrl.start_flush) begin
      // pad with zeros at the low end: pending bits sit above a zero byte
      acc_nxt   = AccW'(pend_r) << BYTE_BITS;
      count_nxt = CntW'(pcnt_r) + CntW'(BYTE_BITS);
      flush_nxt = 1'b1;
    end

    if (ctrl.emit) begin
      count_nxt  = count_less;
      obyte_nxt  = shifted[BYTE_BITS-1:0];
      olast_nxt  = (count_less < CntW'(BYTE_BITS));
      bcount_nxt = (bcount_r == '1) ? bcount_r : bcount_r + COUNT_BITS'(1);
      ovalid_nxt = 1'b1;
    end

    if (ctrl.finish) begin
      if (flush_r) begin
        pend_nxt = '0;
        pcnt_nxt = '0;
      end else begin
        pend_nxt = acc_r[PEND_BITS-1:0] & ~({PEND_BITS{1'b1}} << count_r[PCNT_BITS-1:0]);
        pcnt_nxt = count_r[PCNT_BITS-1:0];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      flush_r  <= 1'b0;
      pend_r   <= '0;
      pcnt_r   <= '0;
      bcount_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      flush_r  <= flush_nxt;
      pend_r   <= pend_nxt;
      pcnt_r   <= pcnt_nxt;
      bcount_r <= bcount_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid         = ovalid_r;
  assign out_byte          = obyte_r;
  assign out_last_of_run   = olast_r;
  assign out_bytes_emitted = bcount_r;

endmodule
